/* rtl/blm_pkg.sv */
package blm_pkg;

  // Default group size for one averaged reading.
  localparam int SAMPLES_PER_READING_DEF = 16;

  // Item kinds carried in the opcode field.
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_DIVIDER_FACTOR = 3'd0,
    CFG_SHUTDOWN_MV    = 3'd1,
    CFG_CRITICAL_MV    = 3'd2,
    CFG_LOW_MV         = 3'd3,
    CFG_GOOD_MV        = 3'd4,
    CFG_WARN_INTERVAL  = 3'd5
  } cfg_index_e;

  // Configuration reset values.
  localparam logic [11:0] DIVIDER_FACTOR_RST = 12'd512;
  localparam logic [15:0] SHUTDOWN_MV_RST    = 16'd3000;
  localparam logic [15:0] CRITICAL_MV_RST    = 16'd3300;
  localparam logic [15:0] LOW_MV_RST         = 16'd3500;
  localparam logic [15:0] GOOD_MV_RST        = 16'd3900;
  localparam logic [23:0] WARN_INTERVAL_RST  = 24'd60000;

  typedef enum logic [2:0] {
    LVL_SHUTDOWN = 3'd0,
    LVL_CRITICAL = 3'd1,
    LVL_LOW      = 3'd2,
    LVL_GOOD     = 3'd3,
    LVL_FULL     = 3'd4
  } level_e;

  typedef struct packed {
    logic        opcode;
    logic [11:0] sample_mv;
  } item_t;

  typedef struct packed {
    logic [15:0] voltage_mv;
    logic [6:0]  charge_percent;
    logic [2:0]  level_code;
    logic        warning;
    logic        reading_done;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV_MUL,
    ST_DIV_FIX,
    ST_SCALE,
    ST_FINISH,
    ST_EMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic exec;
    logic div_mul;
    logic div_fix;
    logic scale;
    logic finish;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic reading;
  } status_t;

endpackage

/* rtl/battery_level_monitor_core.sv */
// A tick, or a sample that does not close a group, goes from acceptance through
// the exec step to its result; a group-closing sample also runs the divide,
// scale and finish steps, shared and run in turn by the controller. An item is
// accepted only while idle, so a new item waits until the last result is loaded.
// Reset (rst, synchronous): thresholds, gain and interval return to defaults,
// the running sum, counters and readings clear, and the level reads full.
module battery_level_monitor_core #(
  parameter int SAMPLES_PER_READING = blm_pkg::SAMPLES_PER_READING_DEF
) (
  input  logic             clk,
  input  logic             rst,
  // Input items: a millisecond tick or one ADC sample.
  input  logic             in_valid,
  output logic             in_ready,
  input  blm_pkg::item_t   in_item,
  // Result items: exactly one per input item.
  output logic             out_valid,
  input  logic             out_ready,
  output blm_pkg::result_t out_result,
  // Configuration writes, always ready; the sender issues them only while no
  // item is in flight.
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [23:0]      cfg_data
);

  // The controller sequences each item through the datapath. An item is
  // accepted only in the idle state, but the output register lets the next
  // item be accepted while the previous result still waits downstream.
  blm_pkg::cmd_t    cmd;
  blm_pkg::status_t status;

  blm_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the configuration, the running average state, the
  // reciprocal divider, the gain multiply, the charge curve and the level
  // compares, plus the output register.
  blm_datapath #(
    .SAMPLES_PER_READING (SAMPLES_PER_READING)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_item    (in_item),
    .cmd        (cmd),
    .status     (status),
    .out_result (out_result),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

endmodule

/* rtl/blm_datapath.sv */
module blm_datapath #(
  parameter int SAMPLES_PER_READING = blm_pkg::SAMPLES_PER_READING_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  blm_pkg::item_t   in_item,
  input  blm_pkg::cmd_t    cmd,
  output blm_pkg::status_t status,
  output blm_pkg::result_t out_result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [23:0]      cfg_data
);

  // Averaging divides by a constant: multiply by a floor reciprocal, then one
  // correction step. The estimate is at most one low for any 16-bit sum.
  localparam int DIV_SHIFT = 20;
  localparam int PROD_W    = DIV_SHIFT + 17;
  localparam logic [DIV_SHIFT:0] DIV_RECIP =
    (DIV_SHIFT + 1)'((1 << DIV_SHIFT) / SAMPLES_PER_READING);
  localparam logic [4:0]  GROUP_LEN  = 5'(SAMPLES_PER_READING);
  localparam logic [15:0] GROUP_LEN16 = 16'(SAMPLES_PER_READING);

  // LiPo curve break points.
  localparam logic [15:0] V_TOP  = 16'd4200;
  localparam logic [15:0] V_KNEE = 16'd4000;
  localparam logic [15:0] V_MID  = 16'd3700;
  localparam logic [15:0] V_LOW  = 16'd3500;
  localparam logic [15:0] V_BOT  = 16'd3000;

  // Piecewise-linear charge curve; segment divides are reciprocal multiplies
  // that are exact over each segment's span.
  function automatic logic [6:0] charge_of(input logic [15:0] v);
    logic [8:0]  x;
    logic [17:0] p;
    logic [6:0]  c;
    x = '0;
    p = '0;
    c = '0;
    if (v >= V_TOP) begin
      c = 7'd100;
    end else if (v <= V_BOT) begin
      c = 7'd0;
    end else if (v >= V_KNEE) begin
      x = 9'(v - V_KNEE);
      p = 18'(x) * 18'd205;
      c = 7'd80 + 7'(p >> 11);
    end else if (v >= V_MID) begin
      x = 9'(v - V_MID);
      p = 18'(x) * 18'd171;
      c = 7'd30 + 7'(p >> 10);
    end else if (v >= V_LOW) begin
      x = 9'(v - V_LOW);
      p = 18'(x) * 18'd205;
      c = 7'd10 + 7'(p >> 11);
    end else begin
      x = 9'(v - V_BOT);
      p = 18'(x) * 18'd41;
      c = 7'(p >> 11);
    end
    return c;
  endfunction

  // Configuration registers.
  logic [11:0] divider_factor;
  logic [15:0] shutdown_mv;
  logic [15:0] critical_mv;
  logic [15:0] low_mv;
  logic [15:0] good_mv;
  logic [23:0] warn_interval;

  // Block state.
  logic [15:0]     sample_sum;
  logic [3:0]      sample_count;
  logic [15:0]     voltage_reg;
  logic [6:0]      percent_reg;
  blm_pkg::level_e level_reg;
  logic [23:0]     since_warning;

  // Item and working registers.
  logic              op_q;
  logic [11:0]       sample_q;
  logic              warn_q;
  logic              done_q;
  logic [15:0]       dividend;
  logic [15:0]       quot_est;
  logic [15:0]       avg;
  logic [27:0]       scale_prod;

  // Combinational terms.
  logic [15:0]       sum_add;
  logic [4:0]        count_inc;
  logic              reading;
  logic [23:0]       since_inc;
  logic              warn_c;
  logic [PROD_W-1:0] div_prod;
  logic [15:0]       div_rem;
  logic [19:0]       scaled_wide;
  logic [15:0]       scaled;
  blm_pkg::level_e   level_c;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      divider_factor <= blm_pkg::DIVIDER_FACTOR_RST;
      shutdown_mv    <= blm_pkg::SHUTDOWN_MV_RST;
      critical_mv    <= blm_pkg::CRITICAL_MV_RST;
      low_mv         <= blm_pkg::LOW_MV_RST;
      good_mv        <= blm_pkg::GOOD_MV_RST;
      warn_interval  <= blm_pkg::WARN_INTERVAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        blm_pkg::CFG_DIVIDER_FACTOR: divider_factor <= cfg_data[11:0];
        blm_pkg::CFG_SHUTDOWN_MV:    shutdown_mv    <= cfg_data[15:0];
        blm_pkg::CFG_CRITICAL_MV:    critical_mv    <= cfg_data[15:0];
        blm_pkg::CFG_LOW_MV:         low_mv         <= cfg_data[15:0];
        blm_pkg::CFG_GOOD_MV:        good_mv        <= cfg_data[15:0];
        blm_pkg::CFG_WARN_INTERVAL:  warn_interval  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    sum_add   = sample_sum + {4'b0, sample_q};
    count_inc = {1'b0, sample_count} + 5'd1;
    reading   = (op_q == blm_pkg::OP_SAMPLE) && (count_inc >= GROUP_LEN);
    since_inc = (since_warning == 24'hFFFFFF) ? since_warning : since_warning + 24'd1;
    warn_c    = (op_q == blm_pkg::OP_TICK) &&
                ((level_reg == blm_pkg::LVL_LOW) || (level_reg == blm_pkg::LVL_CRITICAL)) &&
                (since_inc >= warn_interval);
    div_prod  = PROD_W'(dividend) * PROD_W'(DIV_RECIP);
    div_rem   = dividend - 16'(quot_est * GROUP_LEN16);
    scaled_wide = scale_prod[27:8];
    scaled    = (|scaled_wide[19:16]) ? 16'hFFFF : scaled_wide[15:0];
    if (scaled < shutdown_mv) begin
      level_c = blm_pkg::LVL_SHUTDOWN;
    end else if (scaled < critical_mv) begin
      level_c = blm_pkg::LVL_CRITICAL;
    end else if (scaled < low_mv) begin
      level_c = blm_pkg::LVL_LOW;
    end else if (scaled < good_mv) begin
      level_c = blm_pkg::LVL_GOOD;
    end else begin
      level_c = blm_pkg::LVL_FULL;
    end
  end

  assign status.reading = reading;

  // Stored state with a reset value.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum    <= '0;
      sample_count  <= '0;
      voltage_reg   <= '0;
      percent_reg   <= '0;
      level_reg     <= blm_pkg::LVL_FULL;
      since_warning <= '0;
    end else begin
      if (cmd.exec) begin
        if (op_q == blm_pkg::OP_SAMPLE) begin
          if (reading) begin
            sample_sum   <= '0;
            sample_count <= '0;
          end else begin
            sample_sum   <= sum_add;
            sample_count <= count_inc[3:0];
          end
        end else begin
          since_warning <= warn_c ? 24'd0 : since_inc;
        end
      end
      if (cmd.finish) begin
        voltage_reg <= scaled;
        percent_reg <= charge_of(scaled);
        level_reg   <= level_c;
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_q     <= in_item.opcode;
      sample_q <= in_item.sample_mv;
    end
    if (cmd.exec) begin
      warn_q   <= warn_c;
      done_q   <= reading;
      dividend <= sum_add;
    end
    if (cmd.div_mul) begin
      quot_est <= div_prod[DIV_SHIFT +: 16];
    end
    if (cmd.div_fix) begin
      avg <= (div_rem >= GROUP_LEN16) ? quot_est + 16'd1 : quot_est;
    end
    if (cmd.scale) begin
      scale_prod <= 28'(avg) * 28'(divider_factor);
    end
    if (cmd.emit) begin
      out_result.voltage_mv     <= voltage_reg;
      out_result.charge_percent <= percent_reg;
      out_result.level_code     <= level_reg;
      out_result.warning        <= cmd.exec ? warn_c : warn_q;
      out_result.reading_done   <= cmd.exec ? 1'b0 : done_q;
    end
  end

endmodule

/* rtl/blm_controller.sv */
module blm_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  blm_pkg::status_t status,
  output blm_pkg::cmd_t    cmd
);

  blm_pkg::state_e state;
  blm_pkg::state_e state_next;
  logic            out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= blm_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      blm_pkg::ST_IDLE: begin
        if (in_valid) state_next = blm_pkg::ST_EXEC;
      end
      blm_pkg::ST_EXEC: begin
        if (status.reading) begin
          state_next = blm_pkg::ST_DIV_MUL;
        end else if (out_free) begin
          state_next = blm_pkg::ST_IDLE;
        end else begin
          state_next = blm_pkg::ST_EMIT;
        end
      end
      blm_pkg::ST_DIV_MUL: state_next = blm_pkg::ST_DIV_FIX;
      blm_pkg::ST_DIV_FIX: state_next = blm_pkg::ST_SCALE;
      blm_pkg::ST_SCALE:   state_next = blm_pkg::ST_FINISH;
      blm_pkg::ST_FINISH:  state_next = blm_pkg::ST_EMIT;
      blm_pkg::ST_EMIT: begin
        if (out_free) state_next = blm_pkg::ST_IDLE;
      end
      default: state_next = blm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state == blm_pkg::ST_IDLE);
    cmd           = '0;
    cmd.load_item = in_valid && in_ready;
    case (state)
      blm_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
        cmd.emit = !status.reading && out_free;
      end
      blm_pkg::ST_DIV_MUL: cmd.div_mul = 1'b1;
      blm_pkg::ST_DIV_FIX: cmd.div_fix = 1'b1;
      blm_pkg::ST_SCALE:   cmd.scale   = 1'b1;
      blm_pkg::ST_FINISH:  cmd.finish  = 1'b1;
      blm_pkg::ST_EMIT:    cmd.emit    = out_free;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_emit_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken result");

  a_accept_starts_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == blm_pkg::ST_EXEC))
    else $error("accepted item did not start execution");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("loaded result not presented");

  a_one_work_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.exec, cmd.div_mul, cmd.div_fix, cmd.scale, cmd.finish}))
    else $error("more than one datapath step in a cycle");
`endif

endmodule
